// File: rtl/laaet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-arc angle error tracker package
// Shared widths, register indexes and payload types of the tracker.
// ----------------------------------------------------------------------------
package laaet_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int ERROR_BITS_DEF = 32;

   localparam int ANGLE_W    = 16;
   localparam int ERROR_W    = 32;
   localparam int TOL_W      = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic {
      CSR_TARGET_TOL = 1'b0,
      CSR_SAME_TOL   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [TOL_W-1:0] target_change_tolerance;
      logic [TOL_W-1:0] match_tolerance;
   } cfg_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] meas_angle;
      logic               actual_valid;
      logic [ANGLE_W-1:0] cmd_angle;
      logic               target_valid;
   } req_payload_type;

   typedef struct packed {
      logic signed [ERROR_W-1:0] control_error;
      logic [ANGLE_W-1:0]        target_echo;
      logic                      result_valid;
   } rsp_payload_type;

endpackage

// File: rtl/laaet_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-arc angle error tracker channels
// Valid/ready channel interfaces for angle samples and error results.
// ----------------------------------------------------------------------------
interface laaet_req_if;
   import laaet_pkg::*;

   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] meas_angle;
   logic               actual_valid;
   logic [ANGLE_W-1:0] cmd_angle;
   logic               target_valid;

   modport source (
      output valid, meas_angle, actual_valid, cmd_angle, target_valid,
      input  ready
   );

   modport sink (
      input  valid, meas_angle, actual_valid, cmd_angle, target_valid,
      output ready
   );
endinterface

interface laaet_rsp_if;
   import laaet_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [ERROR_W-1:0] control_error;
   logic [ANGLE_W-1:0]        target_echo;
   logic                      result_valid;

   modport source (
      output valid, control_error, target_echo, result_valid,
      input  ready
   );

   modport sink (
      input  valid, control_error, target_echo, result_valid,
      output ready
   );
endinterface

// File: rtl/laaet_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-arc angle error tracker register file
// APB-style write and read access to the two tolerance registers.
// ----------------------------------------------------------------------------
module laaet_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [laaet_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [laaet_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [laaet_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output laaet_pkg::cfg_type                  cfg
);
   import laaet_pkg::*;

   logic [TOL_W-1:0] target_tol_ff;
   logic [TOL_W-1:0] target_tol_in;
   logic [TOL_W-1:0] same_tol_ff;
   logic [TOL_W-1:0] same_tol_in;
   logic             wr_en;
   csr_index_type    idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      target_tol_in = target_tol_ff;
      same_tol_in   = same_tol_ff;
      csr_prdata    = '0;
      unique case (idx)
         CSR_TARGET_TOL: begin
            csr_prdata = CSR_DATA_W'(target_tol_ff);
            if (wr_en) begin
               target_tol_in = csr_pwdata[TOL_W-1:0];
            end
         end
         CSR_SAME_TOL: begin
            csr_prdata = CSR_DATA_W'(same_tol_ff);
            if (wr_en) begin
               same_tol_in = csr_pwdata[TOL_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_tol_ff <= '0;
         same_tol_ff   <= '0;
      end else begin
         target_tol_ff <= target_tol_in;
         same_tol_ff   <= same_tol_in;
      end
   end

   assign cfg.target_change_tolerance = target_tol_ff;
   assign cfg.match_tolerance         = same_tol_ff;

endmodule

// File: rtl/laaet_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-arc angle error tracker core
// Tracking state and the single-pass error update for one sample.
// ----------------------------------------------------------------------------
module laaet_core #(
   parameter int ANGLE_BITS = laaet_pkg::ANGLE_BITS_DEF,
   parameter int ERROR_BITS = laaet_pkg::ERROR_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  laaet_pkg::cfg_type         cfg,
   input  laaet_pkg::req_payload_type item,
   output laaet_pkg::rsp_payload_type result
);
   import laaet_pkg::*;

   localparam int SUM_BITS = ((ERROR_BITS > ANGLE_BITS + 1) ? ERROR_BITS : ANGLE_BITS + 1) + 1;
   localparam logic signed [SUM_BITS-1:0] ONE_TURN =
      {{(SUM_BITS-ANGLE_BITS-1){1'b0}}, 1'b1, {ANGLE_BITS{1'b0}}};
   localparam logic signed [ERROR_BITS-1:0] ERR_MAX = {1'b0, {(ERROR_BITS-1){1'b1}}};
   localparam logic signed [ERROR_BITS-1:0] ERR_MIN = {1'b1, {(ERROR_BITS-1){1'b0}}};

   function automatic logic signed [ERROR_BITS-1:0] sat_err(
      input logic signed [SUM_BITS-1:0] v
   );
      logic [SUM_BITS-ERROR_BITS:0] hi;
      hi = v[SUM_BITS-1:ERROR_BITS-1];
      priority if ((&hi) || !(|hi)) begin
         return v[ERROR_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         return ERR_MIN;
      end else begin
         return ERR_MAX;
      end
   endfunction

   logic                         goal_active_ff;
   logic                         goal_active_in;
   logic [ANGLE_BITS-1:0]        last_angle_ff;
   logic [ANGLE_BITS-1:0]        last_angle_in;
   logic [ANGLE_BITS-1:0]        held_target_ff;
   logic [ANGLE_BITS-1:0]        held_target_in;
   logic signed [ERROR_BITS-1:0] travel_left_ff;
   logic signed [ERROR_BITS-1:0] travel_left_in;

   logic [ANGLE_BITS-1:0]        actual;
   logic [ANGLE_BITS-1:0]        target;
   logic                         inputs_ok;
   logic signed [ANGLE_BITS-1:0] movement;
   logic signed [SUM_BITS-1:0]   acc_sum;
   logic signed [ERROR_BITS-1:0] travel_acc;
   logic [ANGLE_BITS-1:0]        tgt_diff;
   logic [ANGLE_BITS-1:0]        tgt_mag;
   logic                         fresh;
   logic signed [ANGLE_BITS-1:0] span;
   logic [ANGLE_BITS-1:0]        span_mag;
   logic                         near;
   logic                         span_pos;
   logic signed [SUM_BITS-1:0]   span_ext;
   logic signed [SUM_BITS-1:0]   move_sum;
   logic signed [ERROR_BITS-1:0] travel_new;
   logic signed [ERROR_BITS-1:0] travel_sel;

   always_comb begin
      actual    = ANGLE_BITS'(item.meas_angle);
      target    = ANGLE_BITS'(item.cmd_angle);
      inputs_ok = item.actual_valid && item.target_valid;

      movement   = $signed(actual - last_angle_ff);
      acc_sum    = SUM_BITS'(travel_left_ff) - SUM_BITS'(movement);
      travel_acc = goal_active_ff ? sat_err(acc_sum) : travel_left_ff;

      tgt_diff = target - held_target_ff;
      tgt_mag  = tgt_diff[ANGLE_BITS-1] ? (~tgt_diff + ANGLE_BITS'(1)) : tgt_diff;
      fresh    = !goal_active_ff ||
                 (tgt_mag > ANGLE_BITS'(cfg.target_change_tolerance));

      span     = $signed(target - actual);
      span_mag = span[ANGLE_BITS-1] ? (~span + ANGLE_BITS'(1)) : span;
      near     = span_mag <= ANGLE_BITS'(cfg.match_tolerance);
      span_pos = !span[ANGLE_BITS-1] && (|span);
      span_ext = SUM_BITS'(span);
      move_sum = span_pos ? (span_ext - ONE_TURN) : (span_ext + ONE_TURN);
      travel_new = near ? '0 : sat_err(move_sum);

      travel_sel = fresh ? travel_new : travel_acc;

      goal_active_in = goal_active_ff;
      last_angle_in  = last_angle_ff;
      held_target_in = held_target_ff;
      travel_left_in = travel_left_ff;
      if (step) begin
         if (!inputs_ok) begin
            goal_active_in = 1'b0;
         end else begin
            goal_active_in = 1'b1;
            last_angle_in  = actual;
            travel_left_in = travel_sel;
            if (fresh) begin
               held_target_in = target;
            end
         end
      end

      if (inputs_ok) begin
         result.control_error = ERROR_W'(travel_sel);
         result.target_echo   = ANGLE_W'(target);
         result.result_valid  = 1'b1;
      end else begin
         result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_active_ff <= 1'b0;
         last_angle_ff  <= '0;
         held_target_ff <= '0;
         travel_left_ff <= '0;
      end else begin
         goal_active_ff <= goal_active_in;
         last_angle_ff  <= last_angle_in;
         held_target_ff <= held_target_in;
         travel_left_ff <= travel_left_in;
      end
   end

endmodule

// File: rtl/long_arc_angle_error_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-arc angle error tracker
// Each accepted sample is held in the input register; the core result for it is
// loaded into the output register when that is free or being read, and offered there.
// Throughput: one sample per cycle while results are taken (combinational core update).
// A transfer is accepted while a result waits, as long as the input register is empty.
// Reset is synchronous and active high; it clears the tolerances and the goal.
// ----------------------------------------------------------------------------
module long_arc_angle_error_tracker #(
   parameter int ANGLE_BITS = laaet_pkg::ANGLE_BITS_DEF,
   parameter int ERROR_BITS = laaet_pkg::ERROR_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   laaet_req_if.sink                        req_bus,
   laaet_rsp_if.source                      rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [laaet_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [laaet_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [laaet_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import laaet_pkg::*;

   cfg_type         cfg;
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;
   req_payload_type in_data_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   rsp_payload_type core_result;
   logic            out_free;
   logic            step;

   laaet_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   laaet_core #(
      .ANGLE_BITS (ANGLE_BITS),
      .ERROR_BITS (ERROR_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .item   (in_data_ff),
      .result (core_result)
   );

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_bus.ready) begin
         in_valid_in             = req_bus.valid;
         in_data_in.meas_angle   = req_bus.meas_angle;
         in_data_in.actual_valid = req_bus.actual_valid;
         in_data_in.cmd_angle    = req_bus.cmd_angle;
         in_data_in.target_valid = req_bus.target_valid;
      end
      if (out_free) begin
         out_valid_in = in_valid_ff;
         out_data_in  = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.control_error = out_data_ff.control_error;
   assign rsp_bus.target_echo   = out_data_ff.target_echo;
   assign rsp_bus.result_valid  = out_data_ff.result_valid;

endmodule

// File: tb/sv/laaet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-arc angle error tracker checker
// Watches the sample, result and register ports, predicts the result of
// every sample transfer with its own tracking model, and compares each
// result transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module laaet_checker (
   input  logic                             clock,
   input  logic                             reset,
   laaet_req_if                             req_mon,
   laaet_rsp_if                             rsp_mon,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [laaet_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [laaet_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                             csr_pready,
   output int unsigned                      fail_count,
   output int unsigned                      outstanding
);
   import laaet_pkg::*;

   localparam longint ERR_HI = (longint'(1) << (ERROR_W - 1)) - 1;
   localparam longint ERR_LO = -ERR_HI - 1;
   localparam longint TURN   = longint'(1) << ANGLE_W;

   logic [TOL_W-1:0]   move_tol;
   logic [TOL_W-1:0]   hold_tol;
   bit                 goal_on;
   logic [ANGLE_W-1:0] prev_angle;
   logic [ANGLE_W-1:0] locked_target;
   longint             travel_cnt;
   int unsigned        errs;
   rsp_payload_type    expected_q[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
      errs        = 0;
   end

   function automatic longint angle_delta(logic [ANGLE_W-1:0] a, logic [ANGLE_W-1:0] b);
      logic [ANGLE_W-1:0] d;
      d = a - b;
      return longint'(signed'(d));
   endfunction

   function automatic longint clamp_err(longint v);
      if (v > ERR_HI) return ERR_HI;
      if (v < ERR_LO) return ERR_LO;
      return v;
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic rsp_payload_type track_angle(req_payload_type s);
      rsp_payload_type r;
      longint          span;
      bit              fresh;
      r = '0;
      if (!s.actual_valid || !s.target_valid) begin
         goal_on = 1'b0;
         return r;
      end
      if (goal_on)
         travel_cnt = clamp_err(travel_cnt - angle_delta(s.meas_angle, prev_angle));
      prev_angle = s.meas_angle;
      fresh = !goal_on ||
              (mag(angle_delta(s.cmd_angle, locked_target)) > longint'(move_tol));
      if (fresh) begin
         span = angle_delta(s.cmd_angle, s.meas_angle);
         if (mag(span) <= longint'(hold_tol))
            travel_cnt = 0;
         else if (span > 0)
            travel_cnt = clamp_err(span - TURN);
         else
            travel_cnt = clamp_err(span + TURN);
         locked_target = s.cmd_angle;
         goal_on       = 1'b1;
      end
      r.control_error = travel_cnt[ERROR_W-1:0];
      r.target_echo   = s.cmd_angle;
      r.result_valid  = 1'b1;
      return r;
   endfunction

   task automatic flag(string field, longint want, longint got);
      errs++;
      if (errs <= 100)
         $error("%s: expected %0d, actual %0d", field, want, got);
   endtask

   always @(posedge clock) begin : watch
      req_payload_type sample;
      rsp_payload_type want;
      if (reset) begin
         move_tol      = '0;
         hold_tol      = '0;
         goal_on       = 1'b0;
         prev_angle    = '0;
         locked_target = '0;
         travel_cnt    = 0;
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               flag("unexpected result transfer, control_error", 0,
                    longint'(rsp_mon.control_error));
            end else begin
               want = expected_q.pop_front();
               if (rsp_mon.control_error !== want.control_error)
                  flag("control_error", longint'(want.control_error),
                       longint'(rsp_mon.control_error));
               if (rsp_mon.target_echo !== want.target_echo)
                  flag("target_echo", longint'(want.target_echo),
                       longint'(rsp_mon.target_echo));
               if (rsp_mon.result_valid !== want.result_valid)
                  flag("result_valid", longint'(want.result_valid),
                       longint'(rsp_mon.result_valid));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            sample.meas_angle   = req_mon.meas_angle;
            sample.actual_valid = req_mon.actual_valid;
            sample.cmd_angle    = req_mon.cmd_angle;
            sample.target_valid = req_mon.target_valid;
            expected_q.push_back(track_angle(sample));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[2]))
               CSR_TARGET_TOL: move_tol = csr_pwdata[TOL_W-1:0];
               CSR_SAME_TOL:   hold_tol = csr_pwdata[TOL_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_q.size();
      fail_count  <= errs;
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-arc angle error tracker testbench
// Drives directed and random angle samples in bursts through several
// tolerance settings, stalls the result side on its own pattern, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
   import laaet_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int unsigned           fail_count;
   int unsigned           outstanding;
   int                    burst_left = 0;
   int                    cur_move_tol = 0;
   int                    cur_hold_tol = 0;

   laaet_req_if req_bus ();
   laaet_rsp_if rsp_bus ();

   always #2 clock = ~clock;

   long_arc_angle_error_tracker u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   laaet_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   task automatic csr_write(csr_index_type idx, logic [TOL_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'($urandom_range(0, 16777215)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == CSR_TARGET_TOL)
         cur_move_tol = int'(value);
      else
         cur_hold_tol = int'(value);
   endtask

   task automatic offer_angles(logic [ANGLE_W-1:0] a, logic av, logic [ANGLE_W-1:0] t,
                               logic tv);
      int gap;
      req_bus.valid        <= 1'b1;
      req_bus.meas_angle   <= a;
      req_bus.actual_valid <= av;
      req_bus.cmd_angle    <= t;
      req_bus.target_valid <= tv;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic retune(logic [TOL_W-1:0] move_tol, logic [TOL_W-1:0] hold_tol);
      settle();
      csr_write(CSR_TARGET_TOL, move_tol);
      csr_write(CSR_SAME_TOL, hold_tol);
   endtask

   task automatic run_moves(int count);
      logic [ANGLE_W-1:0] cur_actual;
      logic [ANGLE_W-1:0] cur_target;
      int                 sent;
      int                 run_len;
      int                 reach;
      int                 step;
      int                 off;
      int                 pick;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 85) begin
            run_len    = $urandom_range(3, 40);
            cur_actual = ANGLE_W'($urandom);
            cur_target = ANGLE_W'($urandom);
            pick       = $urandom_range(0, 3);
            reach      = (pick == 0) ? 32767 : (pick == 1) ? 2000 : 64;
            for (int i = 0; i < run_len && sent < count; i++) begin
               step       = int'($urandom_range(0, 2 * reach)) - reach;
               cur_actual = cur_actual + ANGLE_W'(step);
               pick       = $urandom_range(0, 99);
               if (pick >= 70 && pick < 85) begin
                  off        = int'($urandom_range(0, 2 * (cur_move_tol + 20))) -
                               (cur_move_tol + 20);
                  cur_target = cur_target + ANGLE_W'(off);
               end else if (pick >= 85 && pick < 92) begin
                  off        = int'($urandom_range(0, 2 * (cur_hold_tol + 3))) -
                               (cur_hold_tol + 3);
                  cur_target = cur_actual + ANGLE_W'(off);
               end else if (pick >= 92) begin
                  cur_target = ANGLE_W'($urandom);
               end
               offer_angles(cur_actual, $urandom_range(0, 24) != 0,
                            cur_target, $urandom_range(0, 24) != 0);
               sent++;
            end
         end else begin
            run_len = $urandom_range(1, 10);
            for (int i = 0; i < run_len && sent < count; i++) begin
               offer_angles(ANGLE_W'($urandom), 1'($urandom_range(0, 1)),
                            ANGLE_W'($urandom), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
   endtask

   initial begin : receiver
      int seg_no;
      int seg_len;
      int kind;
      seg_no = 0;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         seg_no++;
         if (seg_no % 12 == 5) begin
            rsp_bus.ready <= 1'b0;
            repeat (100) @(posedge clock);
         end else begin
            kind    = $urandom_range(0, 9);
            seg_len = $urandom_range(8, 120);
            repeat (seg_len) begin
               if (kind < 4)
                  rsp_bus.ready <= 1'b1;
               else if (kind < 7)
                  rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               else
                  rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.meas_angle   <= '0;
      req_bus.actual_valid <= 1'b0;
      req_bus.cmd_angle    <= '0;
      req_bus.target_valid <= 1'b0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(CSR_TARGET_TOL, 8'd0);
      csr_write(CSR_SAME_TOL, 8'd0);
      offer_angles(16'h0000, 1'b0, 16'h0000, 1'b0);
      offer_angles(16'h0000, 1'b1, 16'h0000, 1'b1);
      offer_angles(16'h0000, 1'b1, 16'h0001, 1'b1);
      offer_angles(16'h0000, 1'b1, 16'hFFFF, 1'b1);
      offer_angles(16'h0000, 1'b1, 16'h8000, 1'b1);
      offer_angles(16'h0000, 1'b1, 16'h7FFF, 1'b1);
      offer_angles(16'hFFFF, 1'b1, 16'h7FFF, 1'b1);
      offer_angles(16'h0001, 1'b1, 16'h7FFF, 1'b1);
      offer_angles(16'h8001, 1'b1, 16'h7FFF, 1'b1);
      offer_angles(16'h1234, 1'b0, 16'h7FFF, 1'b1);
      offer_angles(16'h1234, 1'b1, 16'h7FFF, 1'b0);
      offer_angles(16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
      offer_angles(16'h0000, 1'b1, 16'h0000, 1'b1);

      retune(8'd16, 8'd4);
      offer_angles(16'd100, 1'b1, 16'd104, 1'b1);
      offer_angles(16'd100, 1'b1, 16'd120, 1'b1);
      offer_angles(16'd100, 1'b1, 16'd121, 1'b1);
      offer_angles(16'd100, 1'b1, 16'd95, 1'b1);
      offer_angles(16'd100, 1'b1, 16'd96, 1'b1);
      offer_angles(16'd90, 1'b1, 16'd96, 1'b1);

      retune(8'd255, 8'd255);
      offer_angles(16'hFFFF, 1'b0, 16'hFFFF, 1'b0);
      offer_angles(16'h0000, 1'b1, 16'd255, 1'b1);
      offer_angles(16'h0000, 1'b1, 16'hFF00, 1'b1);
      offer_angles(16'h1234, 1'b1, 16'hFF00, 1'b1);

      retune(8'd0, 8'd0);
      run_moves(300);
      retune(8'd255, 8'd255);
      run_moves(300);
      retune(8'd0, 8'd255);
      run_moves(300);
      retune(8'd255, 8'd0);
      run_moves(300);
      retune(TOL_W'($urandom_range(0, 255)), TOL_W'($urandom_range(0, 255)));
      run_moves(325);
      settle();

      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
